// File: hdl/rbs_pkg.sv
// Shared types, constants and the extreme-pair table of the bounding sphere block.
package rbs_pkg;

  localparam int NUM_EXT   = 6;
  localparam int NUM_PAIRS = 15;

  typedef logic signed [31:0] coord_t;
  typedef coord_t [2:0] point_t;
  typedef point_t [NUM_EXT-1:0] pts_t;

  // First extreme slot of pair p, slots ordered minx, miny, minz, maxx, maxy, maxz.
  function automatic logic [2:0] pair_first(input logic [3:0] p);
    logic [2:0] r;
    case (p)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: r = 3'd0;
      4'd5, 4'd6, 4'd7, 4'd8: r = 3'd1;
      4'd9, 4'd10, 4'd11: r = 3'd2;
      4'd12, 4'd13: r = 3'd3;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pair_second(input logic [3:0] p);
    logic [2:0] r;
    case (p)
      4'd0: r = 3'd1;
      4'd1, 4'd5: r = 3'd2;
      4'd2, 4'd6, 4'd9: r = 3'd3;
      4'd3, 4'd7, 4'd10, 4'd12: r = 3'd4;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/rbs_front.sv
// Front end: accepts points, stores them, tracks the six axis extremes per set.
module rbs_front #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 32,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1),
  parameter int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  parameter int DW         = 6 * 96 + CNT_W + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [95:0]         s_tdata,
  input  logic                s_tlast,
  output logic                q_push,
  output logic [DW-1:0]       q_data,
  input  logic                release_set,
  input  logic [AW-1:0]       rd_addr,
  output rbs_pkg::point_t     rd_data
);

  localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int SH = 32 - CW;

  rbs_pkg::point_t mem [MAX_POINTS];

  logic [CNT_W-1:0] count;
  logic             dropped;
  logic             busy;
  rbs_pkg::pts_t    ext;

  logic             accept;
  logic             stored;
  rbs_pkg::point_t  p;
  rbs_pkg::pts_t    ext_next;
  logic [CNT_W-1:0] count_next;
  logic             dropped_next;
  logic [31:0]      raw;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign stored   = (count != CNT_W'(MAX_POINTS));

  always_comb begin
    raw = '0;
    for (int k = 0; k < 3; k++) begin
      raw  = s_tdata[32*k +: 32] << SH;
      p[k] = rbs_pkg::coord_t'($signed(raw) >>> SH);
    end
  end

  always_comb begin
    ext_next = ext;
    if (stored) begin
      if (count == '0) begin
        for (int e = 0; e < rbs_pkg::NUM_EXT; e++) ext_next[e] = p;
      end else begin
        for (int k = 0; k < 3; k++) begin
          if ($signed(p[k]) < $signed(ext[k][k])) ext_next[k] = p;
          if ($signed(p[k]) > $signed(ext[k+3][k])) ext_next[k+3] = p;
        end
      end
    end
  end

  assign count_next   = stored ? count + CNT_W'(1) : count;
  assign dropped_next = dropped | !stored;
  assign q_push       = accept && s_tlast;
  assign q_data       = {count_next, dropped_next, ext_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      busy    <= 1'b0;
    end else begin
      if (accept) begin
        ext <= ext_next;
        if (s_tlast) begin
          // hold off the next set until the back end has reread this one
          count   <= '0;
          dropped <= 1'b0;
          busy    <= 1'b1;
        end else begin
          count   <= count_next;
          dropped <= dropped_next;
        end
      end
      if (release_set) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && stored) mem[count[AW-1:0]] <= p;
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/rbs_queue.sv
// Two-entry queue carrying set descriptors from the front end to the back end.
module rbs_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] slot [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   fill;

  assign empty    = (fill == 2'd0);
  assign full     = (fill == 2'd2);
  assign pop_data = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slot[wptr] <= push_data;
  end

endmodule

// File: hdl/rbs_back.sv
// Back end: pair search, initial sphere, growth pass with shared sqrt and divider.
module rbs_back #(
  parameter int MAX_POINTS = 1024,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1),
  parameter int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  parameter int DW         = 6 * 96 + CNT_W + 1,
  parameter int OUT_W      = ((129 + CNT_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  logic [DW-1:0]       q_data,
  output logic                q_pop,
  output logic                release_set,
  output logic [AW-1:0]       rd_addr,
  input  rbs_pkg::point_t     rd_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PAIR_LD  = 4'd1;
  localparam logic [3:0] ST_D2       = 4'd2;
  localparam logic [3:0] ST_PAIR_CMP = 4'd3;
  localparam logic [3:0] ST_INIT_C   = 4'd4;
  localparam logic [3:0] ST_SQ_INIT  = 4'd5;
  localparam logic [3:0] ST_SQRT     = 4'd6;
  localparam logic [3:0] ST_GROW_RD  = 4'd7;
  localparam logic [3:0] ST_GROW_CAP = 4'd8;
  localparam logic [3:0] ST_GROW_TST = 4'd9;
  localparam logic [3:0] ST_GROW_NR  = 4'd10;
  localparam logic [3:0] ST_DIV_MUL  = 4'd11;
  localparam logic [3:0] ST_DIV      = 4'd12;
  localparam logic [3:0] ST_DIV_UPD  = 4'd13;
  localparam logic [3:0] ST_OUT      = 4'd14;

  localparam logic [1:0] MODE_PAIR = 2'd0;
  localparam logic [1:0] MODE_INIT = 2'd1;
  localparam logic [1:0] MODE_GROW = 2'd2;

  localparam int SQ_ITERS  = 34;
  localparam int DIV_ITERS = 65;
  localparam logic [34:0] R_MAX = 35'h0FFFFFFFF;

  logic [3:0]       state;
  logic [1:0]       mode;

  rbs_pkg::pts_t    pts;
  logic [CNT_W-1:0] cnt;
  logic             drp;

  logic [3:0]       pair;
  logic [67:0]      best;
  logic [2:0]       ia;
  logic [2:0]       ib;

  rbs_pkg::point_t  op_a;
  rbs_pkg::point_t  op_b;
  logic [1:0]       d2_cnt;
  logic [32:0]      magr;
  logic [67:0]      acc;

  logic [67:0]      sq_rad;
  logic [36:0]      sq_rem;
  logic [33:0]      sq_root;
  logic [5:0]       sq_cnt;

  rbs_pkg::point_t  center;
  logic [31:0]      radius;
  logic [63:0]      rsq;
  logic [34:0]      span;
  logic [31:0]      nr;
  logic [31:0]      g;
  logic [CNT_W-1:0] idx;
  logic [1:0]       axis;

  logic [64:0]      dvd;
  logic [34:0]      rem;
  logic [33:0]      quo;
  logic             neg;
  logic [6:0]       dv_cnt;

  // combinational helpers
  logic [1:0]         d2_ax;
  logic signed [32:0] d2_diff;
  logic [32:0]        d2_mag;
  logic [36:0]        rem_sh;
  logic [36:0]        trial;
  logic               sq_take;
  logic [33:0]        root_n;
  logic [36:0]        rem_n;
  logic [34:0]        root_ceil;
  logic [35:0]        dv_nr;
  logic               dv_take;
  logic signed [32:0] dm_diff;
  logic [32:0]        dm_mag;
  logic signed [35:0] c_new;
  logic [35:0]        nr_sum;
  logic [34:0]        nr_half;
  logic [31:0]        nr_sat;
  logic signed [32:0] init_sum [3];
  rbs_pkg::point_t    init_c;
  logic               out_free;

  assign d2_ax   = (d2_cnt == 2'd3) ? 2'd0 : d2_cnt;
  assign d2_diff = $signed({op_a[d2_ax][31], op_a[d2_ax]}) -
                   $signed({op_b[d2_ax][31], op_b[d2_ax]});
  assign d2_mag  = d2_diff[32] ? 33'(-d2_diff) : 33'(d2_diff);

  assign rem_sh    = {sq_rem[34:0], sq_rad[67:66]};
  assign trial     = {1'b0, sq_root, 2'b01};
  assign sq_take   = (rem_sh >= trial);
  assign root_n    = {sq_root[32:0], sq_take};
  assign rem_n     = sq_take ? rem_sh - trial : rem_sh;
  assign root_ceil = {1'b0, root_n} + {34'd0, (rem_n != '0)};

  assign dv_nr   = {rem, dvd[64]};
  assign dv_take = (dv_nr >= {1'b0, span});

  assign dm_diff = $signed({op_a[axis][31], op_a[axis]}) -
                   $signed({center[axis][31], center[axis]});
  assign dm_mag  = dm_diff[32] ? 33'(-dm_diff) : 33'(dm_diff);

  assign c_new = neg ? $signed({{4{center[axis][31]}}, center[axis]}) - $signed({2'b00, quo})
                     : $signed({{4{center[axis][31]}}, center[axis]}) + $signed({2'b00, quo});

  assign nr_sum  = {4'd0, radius} + {1'b0, span} + 36'd1;
  assign nr_half = nr_sum[35:1];
  assign nr_sat  = (nr_half > R_MAX) ? 32'hFFFFFFFF : nr_half[31:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      init_sum[k] = $signed({pts[ia][k][31], pts[ia][k]}) +
                    $signed({pts[ib][k][31], pts[ib][k]});
      init_c[k]   = rbs_pkg::coord_t'(init_sum[k] >>> 1);
    end
  end

  assign out_free    = !m_tvalid || m_tready;
  assign q_pop       = (state == ST_IDLE) && !q_empty;
  assign release_set = (state == ST_OUT) && out_free;
  assign rd_addr     = idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= MODE_PAIR;
      m_tvalid <= 1'b0;
    end else begin
      // the output step reloads the register in the same cycle it drains
      if (m_tvalid && m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            pts   <= q_data[6*96-1:0];
            drp   <= q_data[6*96];
            cnt   <= q_data[6*96+1 +: CNT_W];
            pair  <= 4'd0;
            best  <= '0;
            ia    <= 3'd0;
            ib    <= 3'd0;
            state <= ST_PAIR_LD;
          end
        end
        ST_PAIR_LD: begin
          op_a   <= pts[rbs_pkg::pair_first(pair)];
          op_b   <= pts[rbs_pkg::pair_second(pair)];
          mode   <= MODE_PAIR;
          d2_cnt <= 2'd0;
          state  <= ST_D2;
        end
        ST_D2: begin
          // square of the previous axis accumulates while the next difference forms
          if (d2_cnt == 2'd0) acc <= '0;
          else acc <= acc + 68'(magr * magr);
          magr   <= d2_mag;
          d2_cnt <= d2_cnt + 2'd1;
          if (d2_cnt == 2'd3) begin
            case (mode)
              MODE_PAIR: state <= ST_PAIR_CMP;
              MODE_INIT: state <= ST_SQ_INIT;
              default:   state <= ST_GROW_TST;
            endcase
          end
        end
        ST_PAIR_CMP: begin
          if (acc > best) begin
            best <= acc;
            ia   <= rbs_pkg::pair_first(pair);
            ib   <= rbs_pkg::pair_second(pair);
          end
          pair <= pair + 4'd1;
          if (pair == 4'(rbs_pkg::NUM_PAIRS - 1)) state <= ST_INIT_C;
          else state <= ST_PAIR_LD;
        end
        ST_INIT_C: begin
          center <= init_c;
          op_a   <= pts[ib];
          op_b   <= init_c;
          mode   <= MODE_INIT;
          d2_cnt <= 2'd0;
          state  <= ST_D2;
        end
        ST_SQ_INIT: begin
          sq_rad  <= acc;
          sq_rem  <= '0;
          sq_root <= '0;
          sq_cnt  <= '0;
          state   <= ST_SQRT;
        end
        ST_SQRT: begin
          sq_rad  <= {sq_rad[65:0], 2'b00};
          sq_rem  <= rem_n;
          sq_root <= root_n;
          sq_cnt  <= sq_cnt + 6'd1;
          if (sq_cnt == 6'(SQ_ITERS - 1)) begin
            if (mode == MODE_INIT) begin
              radius <= (root_ceil > R_MAX) ? 32'hFFFFFFFF : root_ceil[31:0];
              idx    <= '0;
              state  <= ST_GROW_RD;
            end else begin
              span  <= root_ceil;
              state <= ST_GROW_NR;
            end
          end
        end
        ST_GROW_RD: begin
          state <= ST_GROW_CAP;
        end
        ST_GROW_CAP: begin
          op_a   <= rd_data;
          op_b   <= center;
          rsq    <= radius * radius;
          mode   <= MODE_GROW;
          d2_cnt <= 2'd0;
          state  <= ST_D2;
        end
        ST_GROW_TST: begin
          if (acc > {4'd0, rsq}) begin
            state <= ST_SQ_INIT;
          end else if (idx + CNT_W'(1) == cnt) begin
            state <= ST_OUT;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= ST_GROW_RD;
          end
        end
        ST_GROW_NR: begin
          nr    <= (nr_sat < radius) ? radius : nr_sat;
          g     <= ((nr_sat < radius) ? radius : nr_sat) - radius;
          axis  <= 2'd0;
          state <= ST_DIV_MUL;
        end
        ST_DIV_MUL: begin
          dvd    <= 65'(dm_mag * g);
          neg    <= dm_diff[32];
          rem    <= '0;
          quo    <= '0;
          dv_cnt <= '0;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          dvd    <= {dvd[63:0], 1'b0};
          rem    <= dv_take ? 35'(dv_nr - {1'b0, span}) : dv_nr[34:0];
          quo    <= {quo[32:0], dv_take};
          dv_cnt <= dv_cnt + 7'd1;
          if (dv_cnt == 7'(DIV_ITERS - 1)) state <= ST_DIV_UPD;
        end
        ST_DIV_UPD: begin
          if (c_new > 36'sd2147483647) center[axis] <= 32'sh7FFFFFFF;
          else if (c_new < -36'sd2147483648) center[axis] <= 32'sh80000000;
          else center[axis] <= rbs_pkg::coord_t'(c_new);
          if (axis == 2'd2) begin
            radius <= nr;
            if (idx + CNT_W'(1) == cnt) begin
              state <= ST_OUT;
            end else begin
              idx   <= idx + CNT_W'(1);
              state <= ST_GROW_RD;
            end
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_DIV_MUL;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tdata  <= {(OUT_W - 129 - CNT_W)'(0), drp, cnt, radius,
                         center[2], center[1], center[0]};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (span != '0))
    else $error("divider running with zero divisor");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_OUT))
    else $error("result raised outside the output step");

  a_sqrt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT) |-> (sq_cnt < 6'(SQ_ITERS)))
    else $error("square root ran past its last digit");

  a_grow_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GROW_RD) |-> (idx < cnt))
    else $error("growth pass reading beyond the stored points");

endmodule

// File: hdl/ritter_bounding_sphere.sv
// Top level of the Ritter bounding sphere block: front end, descriptor queue, back end.
//
// Input stream s_*: one point per item, x/y/z in tdata, tlast marks the final point
// of a set. Points load at one per cycle into an internal store of MAX_POINTS entries;
// points beyond that are dropped and flagged in the result.
// After the last point, s_tready stays low until the back end has finished rereading
// the store. The back end then runs the extreme pair search, forms the initial sphere
// and runs the inside test on each stored point; each point that grows the sphere
// takes a bit-serial square root, then one 65-step divider pass per axis.
// Output stream m_*: one item per set with center, radius, point count and overflow.
// The result sits in an output register; if the receiver stalls, the back end holds
// the next result, and the front end keeps loading the next set up to its last point.
// Reset (rst, synchronous) empties the queue and clears counts and flags; the store
// itself needs no clearing since only entries written in the current set are read.
module ritter_bounding_sphere #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 32,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1),
  parameter int OUT_W      = ((129 + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [95:0]      s_tdata,   // point_x, point_y, point_z
  input  logic             s_tlast,   // last_point
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // ctr_x, ctr_y, ctr_z, radius,
                                      // point_count, overflow, zero pad
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int DW = 6 * 96 + CNT_W + 1;

  logic            q_push;
  logic [DW-1:0]   q_wdata;
  logic            q_pop;
  logic [DW-1:0]   q_rdata;
  logic            q_empty;
  logic            q_full;
  logic            release_set;
  logic [AW-1:0]   rd_addr;
  rbs_pkg::point_t rd_data;

  rbs_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .CNT_W      (CNT_W),
    .AW         (AW),
    .DW         (DW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .release_set (release_set),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  rbs_queue #(
    .W (DW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty),
    .full      (q_full)
  );

  rbs_back #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W),
    .AW         (AW),
    .DW         (DW),
    .OUT_W      (OUT_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .release_set (release_set),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("set descriptor pushed into a full queue");

endmodule
